// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the loader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/srl_pkg.sv
// Types and constants of the S-record S1 loader.
package srl_pkg;

  localparam int unsigned ADDR_WIDTH = 16;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_S   = 8'h53;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] MIN_COUNT = 8'd3;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_OK      = 3'd1,
    KIND_FAIL    = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_FORMAT  = 3'd4,
    KIND_DONE    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ADDR_WIDTH-1:0] write_address;
    logic [7:0]            write_data;
    logic                  load_ok;
  } out_item_t;

  // Classified character, as queued between front and back.
  typedef struct packed {
    logic       eoi;
    logic       eol;
    logic       is_s;
    logic       is_one;
    logic       is_hex;
    logic [3:0] hex_val;
  } token_t;

endpackage

// File: hw/rtl/srl_front.sv
// Front end: classify one incoming character into a token.
module srl_front (
  input  srl_pkg::in_item_t item_i,
  output srl_pkg::token_t   token_o
);

  logic [7:0] c;
  logic [7:0] diff;

  assign c = item_i.character;

  always_comb begin
    token_o         = '0;
    token_o.eoi     = item_i.end_of_input;
    token_o.eol     = (c == srl_pkg::CHAR_LF) || (c == srl_pkg::CHAR_CR);
    token_o.is_s    = (c == srl_pkg::CHAR_S);
    token_o.is_one  = (c == srl_pkg::CHAR_ONE);
    diff            = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      token_o.is_hex = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      token_o.is_hex = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      token_o.is_hex = 1'b1;
    end
    token_o.hex_val = diff[3:0];
  end

endmodule

// File: hw/rtl/srl_fifo.sv
// Token queue between the front end and the parser.
`include "assert_macros.svh"

module srl_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srl_pkg::token_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output srl_pkg::token_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  srl_pkg::token_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SRL_ASSERT_ALWAYS(a_fifo_bound, !rst_ni || (cnt_q <= FullCnt), "token queue count above depth")
  `SRL_ASSERT(a_fifo_count, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1),
              "token queue count did not advance on push")

endmodule

// File: hw/rtl/srl_back.sv
// Back end: S-record parse state machine and result register.
`include "assert_macros.svh"

module srl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  srl_pkg::token_t    tok_i,
  output logic               tok_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srl_pkg::out_item_t out_data_o
);

  localparam logic [3:0] PH_LINE_START = 4'd0;
  localparam logic [3:0] PH_TYPE       = 4'd1;
  localparam logic [3:0] PH_COUNT      = 4'd2;
  localparam logic [3:0] PH_ADDR_HI    = 4'd3;
  localparam logic [3:0] PH_ADDR_LO    = 4'd4;
  localparam logic [3:0] PH_DATA       = 4'd5;
  localparam logic [3:0] PH_CHECKSUM   = 4'd6;
  localparam logic [3:0] PH_TAIL       = 4'd7;
  localparam logic [3:0] PH_SKIP       = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [3:0] high_q, high_d;
  logic       pend_q, pend_d;
  logic [7:0] count_q, count_d;
  logic [srl_pkg::ADDR_WIDTH-1:0] addr_q, addr_d;
  logic [7:0] off_q, off_d;
  logic [7:0] sum_q, sum_d;
  logic       fail_q, fail_d;
  logic       out_valid_q, out_valid_d;
  srl_pkg::out_item_t out_q, res;
  logic       has_res;
  logic       pop;
  logic [7:0] byte_val;

  // Take a token only when the result register is free or draining.
  assign pop         = tok_valid_i && (!out_valid_q || out_ready_i);
  assign tok_pop_o   = pop;
  assign byte_val    = {high_q, tok_i.hex_val};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d = phase_q;
    high_d  = high_q;
    pend_d  = pend_q;
    count_d = count_q;
    addr_d  = addr_q;
    off_d   = off_q;
    sum_d   = sum_q;
    fail_d  = fail_q;
    res     = '0;
    has_res = 1'b0;
    if (pop) begin
      if (tok_i.eoi) begin
        res.kind    = srl_pkg::KIND_DONE;
        res.load_ok = !fail_q;
        has_res     = 1'b1;
        phase_d     = PH_LINE_START;
        high_d      = '0;
        pend_d      = 1'b0;
        count_d     = '0;
        addr_d      = '0;
        off_d       = '0;
        sum_d       = '0;
        fail_d      = 1'b0;
      end else begin
        case (phase_q)
          PH_LINE_START: begin
            if (!tok_i.eol) begin
              if (tok_i.is_s) begin
                phase_d = PH_TYPE;
              end else begin
                phase_d  = PH_SKIP;
                res.kind = srl_pkg::KIND_UNKNOWN;
                has_res  = 1'b1;
              end
            end
          end
          PH_TYPE: begin
            if (tok_i.eol) begin
              phase_d = PH_LINE_START;
            end else if (tok_i.is_one) begin
              phase_d = PH_COUNT;
              pend_d  = 1'b0;
              high_d  = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_CHECKSUM: begin
            if (tok_i.eol || !tok_i.is_hex) begin
              phase_d  = tok_i.eol ? PH_LINE_START : PH_SKIP;
              pend_d   = 1'b0;
              res.kind = srl_pkg::KIND_FORMAT;
              has_res  = 1'b1;
            end else if (!pend_q) begin
              high_d = tok_i.hex_val;
              pend_d = 1'b1;
            end else begin
              pend_d = 1'b0;
              case (phase_q)
                PH_COUNT: begin
                  if (byte_val < srl_pkg::MIN_COUNT) begin
                    phase_d  = PH_SKIP;
                    res.kind = srl_pkg::KIND_FORMAT;
                    has_res  = 1'b1;
                  end else begin
                    count_d = byte_val;
                    sum_d   = byte_val;
                    phase_d = PH_ADDR_HI;
                  end
                end
                PH_ADDR_HI: begin
                  addr_d  = {byte_val, 8'h00};
                  sum_d   = sum_q + byte_val;
                  phase_d = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                  addr_d  = {addr_q[15:8], byte_val};
                  sum_d   = sum_q + byte_val;
                  off_d   = '0;
                  phase_d = (count_q == srl_pkg::MIN_COUNT) ? PH_CHECKSUM : PH_DATA;
                end
                PH_DATA: begin
                  res.kind          = srl_pkg::KIND_WRITE;
                  res.write_address = addr_q + {8'h00, off_q};
                  res.write_data    = byte_val;
                  has_res           = 1'b1;
                  sum_d             = sum_q + byte_val;
                  off_d             = off_q + 8'd1;
                  if (({1'b0, off_d} + 9'd3) >= {1'b0, count_q}) begin
                    phase_d = PH_CHECKSUM;
                  end
                end
                default: begin
                  phase_d = PH_TAIL;
                  has_res = 1'b1;
                  if (~sum_q == byte_val) begin
                    res.kind = srl_pkg::KIND_OK;
                  end else begin
                    res.kind = srl_pkg::KIND_FAIL;
                    fail_d   = 1'b1;
                  end
                end
              endcase
            end
          end
          default: begin
            if (tok_i.eol) begin
              phase_d = PH_LINE_START;
            end
          end
        endcase
      end
    end
    out_valid_d = pop ? has_res : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LINE_START;
      high_q      <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      addr_q      <= '0;
      off_q       <= '0;
      sum_q       <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      high_q      <= high_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      off_q       <= off_d;
      sum_q       <= sum_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && has_res) begin
      out_q <= res;
    end
  end

  `SRL_ASSERT(a_done_follows_eoi,
              (pop && tok_i.eoi) |=> (out_valid_q && out_q.kind == srl_pkg::KIND_DONE),
              "end of input did not produce load done")
  `SRL_ASSERT(a_pend_in_record,
              pend_q |-> (phase_q == PH_COUNT || phase_q == PH_ADDR_HI ||
                          phase_q == PH_ADDR_LO || phase_q == PH_DATA ||
                          phase_q == PH_CHECKSUM),
              "nibble pending outside a record field")

endmodule

// File: hw/rtl/srecord_s1_loader_top.sv
// Top level of the S-record S1 loader: front end, token queue, parser.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  in       | input     | in_valid_i/in_ready_o  | in_data_i  (character, eoi)
//  out      | output    | out_valid_o/out_ready_i| out_data_o (kind, addr, data, ok)
//
// One character per cycle sustained while the output accepts; from acceptance a
// character passes the queue write, then the parse step into the result register.
// The parse step is one registered state update per token, so the parser loop sets the rate.
// Reset is asynchronous and active low; it empties the queue and returns the
// parser to line start with no failure recorded.
// A stalled output holds the parser; the queue absorbs up to FIFO_DEPTH
// characters before in_ready_o drops.
module srecord_s1_loader_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srl_pkg::out_item_t out_data_o
);

  srl_pkg::token_t front_tok;
  srl_pkg::token_t queue_tok;
  logic            queue_full;
  logic            queue_valid;
  logic            queue_pop;

  // Classify each request as it arrives.
  srl_front u_front (
    .item_i  (in_data_i),
    .token_o (front_tok)
  );

  // Accept whenever the queue has room, independent of the output side.
  assign in_ready_o = !queue_full;

  srl_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !queue_full),
    .push_data_i (front_tok),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_tok)
  );

  // Advance the parser one token per cycle while tokens wait and the result register is free or draining.
  srl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (queue_valid),
    .tok_i       (queue_tok),
    .tok_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: dv/srl_tb_pkg.sv
// Scoreboard of the S-record S1 loader testbench: parse predictor and result queue.
package srl_tb_pkg;
  import srl_pkg::*;

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA,
    PH_CHECKSUM,
    PH_TAIL,
    PH_SKIP
  } parse_phase_e;

  class srl_load_scoreboard;
    parse_phase_e          phase;
    logic [3:0]            high_nib;
    bit                    nib_pending;
    logic [7:0]            byte_count;
    logic [ADDR_WIDTH-1:0] rec_addr;
    logic [7:0]            data_offset;
    logic [7:0]            running_sum;
    bit                    any_failure;
    out_item_t             expected_reports[$];
    int                    errors;

    function new();
      clear_parse();
      any_failure = 1'b0;
      errors      = 0;
    endfunction

    function void clear_parse();
      phase       = PH_LINE_START;
      high_nib    = '0;
      nib_pending = 1'b0;
      byte_count  = '0;
      rec_addr    = '0;
      data_offset = '0;
      running_sum = '0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Value of a hex digit, -1 for anything else.
    function int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    // Consume one assembled record byte.
    function bit take_byte(logic [7:0] b, output out_item_t res);
      res = '0;
      case (phase)
        PH_COUNT: begin
          if (b < MIN_COUNT) begin
            phase    = PH_SKIP;
            res.kind = KIND_FORMAT;
            return 1'b1;
          end
          byte_count  = b;
          running_sum = b;
          phase       = PH_ADDR_HI;
          return 1'b0;
        end
        PH_ADDR_HI: begin
          rec_addr    = {b, 8'h00};
          running_sum = running_sum + b;
          phase       = PH_ADDR_LO;
          return 1'b0;
        end
        PH_ADDR_LO: begin
          rec_addr    = {rec_addr[15:8], b};
          running_sum = running_sum + b;
          data_offset = '0;
          phase       = (byte_count == MIN_COUNT) ? PH_CHECKSUM : PH_DATA;
          return 1'b0;
        end
        PH_DATA: begin
          res.kind          = KIND_WRITE;
          res.write_address = rec_addr + {8'h00, data_offset};
          res.write_data    = b;
          running_sum       = running_sum + b;
          data_offset       = data_offset + 8'd1;
          if (int'(data_offset) + 3 >= int'(byte_count)) phase = PH_CHECKSUM;
          return 1'b1;
        end
        default: begin
          phase = PH_TAIL;
          if (~running_sum == b) begin
            res.kind = KIND_OK;
          end else begin
            res.kind    = KIND_FAIL;
            any_failure = 1'b1;
          end
          return 1'b1;
        end
      endcase
    endfunction

    // Advance the parse by one character; return 1 when a report results.
    function bit parse_char(in_item_t it, output out_item_t res);
      logic [7:0] c;
      bit         eol;
      int         h;
      c   = it.character;
      eol = (c == CHAR_LF) || (c == CHAR_CR);
      res = '0;
      if (it.end_of_input) begin
        res.kind    = KIND_DONE;
        res.load_ok = !any_failure;
        clear_parse();
        any_failure = 1'b0;
        return 1'b1;
      end
      case (phase)
        PH_LINE_START: begin
          if (eol) return 1'b0;
          if (c == CHAR_S) begin
            phase = PH_TYPE;
            return 1'b0;
          end
          phase    = PH_SKIP;
          res.kind = KIND_UNKNOWN;
          return 1'b1;
        end
        PH_TYPE: begin
          if (eol) begin
            phase = PH_LINE_START;
          end else if (c == CHAR_ONE) begin
            phase       = PH_COUNT;
            nib_pending = 1'b0;
            high_nib    = '0;
          end else begin
            phase = PH_SKIP;
          end
          return 1'b0;
        end
        PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_DATA, PH_CHECKSUM: begin
          if (eol) begin
            phase       = PH_LINE_START;
            nib_pending = 1'b0;
            res.kind    = KIND_FORMAT;
            return 1'b1;
          end
          h = hex_value(c);
          if (h < 0) begin
            phase       = PH_SKIP;
            nib_pending = 1'b0;
            res.kind    = KIND_FORMAT;
            return 1'b1;
          end
          if (!nib_pending) begin
            high_nib    = 4'(h);
            nib_pending = 1'b1;
            return 1'b0;
          end
          nib_pending = 1'b0;
          return take_byte({high_nib, 4'(h)}, res);
        end
        default: begin
          if (eol) phase = PH_LINE_START;
          return 1'b0;
        end
      endcase
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      if (parse_char(it, r)) expected_reports.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, what, exp_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d addr %0h data %0h ok %0b",
                 $time, got.kind, got.write_address, got.write_data, got.load_ok);
        return;
      end
      exp_r = expected_reports.pop_front();
      if (exp_r.kind !== got.kind) flag("kind", exp_r.kind, got.kind);
      if (exp_r.write_address !== got.write_address)
        flag("write_address", exp_r.write_address, got.write_address);
      if (exp_r.write_data !== got.write_data) flag("write_data", exp_r.write_data, got.write_data);
      if (exp_r.load_ok !== got.load_ok) flag("load_ok", exp_r.load_ok, got.load_ok);
    endfunction
  endclass

endpackage

// File: dv/srecord_s1_loader_top_tb.sv
// Testbench top of the S-record S1 loader: directed and random file text, checked result by result.
module srecord_s1_loader_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srl_pkg::*;
  import srl_tb_pkg::*;

  // Ways to spoil an otherwise good S1 line.
  typedef enum int {
    FLAW_NONE,
    FLAW_NON_HEX,
    FLAW_TRUNCATE
  } flaw_e;

  localparam int RANDOM_ITEMS = 1400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  srl_load_scoreboard sb = new();

  // Count of accepted requests; steady drops all idling on both sides.
  int sent_count = 0;
  bit steady     = 1'b0;

  srecord_s1_loader_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_hex_or_eol(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66) || c == CHAR_LF || c == CHAR_CR;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex_or_eol(c));
    return c;
  endfunction

  // Any character that does not end a line.
  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  // Present one request and hold it until accepted. Enter and leave on a falling edge.
  task automatic push_char(input logic [7:0] c, input logic eoi);
    int       gap;
    in_item_t it;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.character    = c;
    it.end_of_input = eoi;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(it);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
    push_char(term, 1'b0);
  endtask

  // Close a line with LF, CR, CR LF or a doubled LF.
  task automatic send_eol();
    case ($urandom_range(0, 3))
      0: push_char(CHAR_LF, 1'b0);
      1: push_char(CHAR_CR, 1'b0);
      2: begin
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b0);
      end
      default: begin
        push_char(CHAR_LF, 1'b0);
        push_char(CHAR_LF, 1'b0);
      end
    endcase
  endtask

  // Build an S1 line with random data, optionally spoiled, and send it.
  task automatic send_s1(input logic [15:0] addr, input int ndata, input bit bad_sum,
                         input flaw_e flaw, input bit trailing);
    logic [7:0] bytes[$];
    logic [7:0] line[$];
    logic [7:0] sum;
    bit         lower;
    int         pos;
    lower = 1'($urandom_range(0, 1));
    bytes.push_back(8'(ndata + 3));
    bytes.push_back(addr[15:8]);
    bytes.push_back(addr[7:0]);
    for (int i = 0; i < ndata; i++) bytes.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (bytes[i]) sum += bytes[i];
    sum = ~sum;
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    line.push_back(CHAR_S);
    line.push_back(CHAR_ONE);
    foreach (bytes[i]) begin
      line.push_back(hex_char(bytes[i][7:4], lower));
      line.push_back(hex_char(bytes[i][3:0], lower));
    end
    case (flaw)
      FLAW_NON_HEX: begin
        pos       = $urandom_range(2, line.size() - 1);
        line[pos] = non_hex_char();
      end
      FLAW_TRUNCATE: begin
        pos = $urandom_range(2, line.size() - 1);
        while (line.size() > pos) void'(line.pop_back());
      end
      default: ;
    endcase
    if (trailing) repeat ($urandom_range(1, 4)) line.push_back(line_char());
    foreach (line[i]) push_char(line[i], 1'b0);
    send_eol();
  endtask

  // Draw an address, sometimes close to the top so writes wrap.
  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return 16'hFFFF - 16'($urandom_range(0, 8));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_ndata();
    if ($urandom_range(0, 39) == 0) return $urandom_range(17, 252);
    return $urandom_range(0, 16);
  endfunction

  // One random line: mostly good S1 records, the rest broken records and noise.
  task automatic send_random_line();
    int         r;
    int         n;
    logic [7:0] first;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      send_s1(pick_addr(), pick_ndata(), $urandom_range(0, 9) == 0, FLAW_NONE,
              $urandom_range(0, 7) == 0);
    end else if (r < 72) begin
      send_s1(pick_addr(), pick_ndata(), 1'b0,
              ($urandom_range(0, 1) == 0) ? FLAW_NON_HEX : FLAW_TRUNCATE, 1'b0);
    end else if (r < 75) begin
      // count below the minimum
      push_char(CHAR_S, 1'b0);
      push_char(CHAR_ONE, 1'b0);
      push_char(8'h30, 1'b0);
      push_char(hex_char(4'($urandom_range(0, 2)), 1'b0), 1'b0);
      repeat ($urandom_range(0, 6)) push_char(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b0);
      send_eol();
    end else if (r < 81) begin
      // other S types, S9 among them
      push_char(CHAR_S, 1'b0);
      push_char(($urandom_range(0, 1) == 0) ? 8'h39 : line_char(), 1'b0);
      repeat ($urandom_range(0, 10)) push_char(line_char(), 1'b0);
      send_eol();
    end else if (r < 88) begin
      // unknown line
      n     = $urandom_range(0, 8);
      first = non_hex_char();
      if (first == CHAR_S) first = 8'h00;
      push_char(first, 1'b0);
      repeat (n) push_char(line_char(), 1'b0);
      send_eol();
    end else if (r < 94) begin
      // raw bytes, line ends included
      repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 97) begin
      if ($urandom_range(0, 1) == 0) push_char(CHAR_S, 1'b0);
      send_eol();
    end else begin
      push_char(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Output side: hold ready high, drop it for random stalls.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    int lines;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty lines, bare S, skipped S types, unknown line.
    push_char(CHAR_LF, 1'b0);
    push_char(CHAR_CR, 1'b0);
    push_char(CHAR_LF, 1'b0);
    send_line("S", CHAR_LF);
    send_line("S9030000FC", CHAR_CR);
    send_line("S0030000FC", CHAR_LF);
    send_line("#x", CHAR_LF);
    // Record with no data, then counts below the minimum.
    send_line("S1030000FC", CHAR_LF);
    send_line("S100", CHAR_LF);
    send_line("S1020000", CHAR_LF);
    // Wrap at the top of memory, lowercase digits with data extremes.
    send_s1(16'hFFFE, 4, 1'b0, FLAW_NONE, 1'b1);
    send_line("S1050000ff00fb", CHAR_LF);
    // Checksum failure, non-hex digit, line end before the checksum.
    send_s1(16'h0000, 2, 1'b1, FLAW_NONE, 1'b0);
    send_line("S10G", CHAR_LF);
    send_line("S10500", CHAR_LF);
    // Load done after a failure, extreme characters, then a clean load.
    push_char(8'h00, 1'b1);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CHAR_LF, 1'b0);
    send_s1(16'h1234, 1, 1'b0, FLAW_NONE, 1'b0);
    push_char(8'hFF, 1'b1);
    // End of input in the middle of a record.
    send_line("S10500A", 8'h42);
    push_char(8'h55, 1'b1);

    // Random file text; alternate steady stretches with idling.
    lines = 0;
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (lines % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_line();
      lines++;
    end
    push_char(8'($urandom_range(0, 255)), 1'b1);
    in_valid_i <= 1'b0;

    // Drain, then allow the pipeline latency to pass.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/srl_pkg.sv
hw/rtl/srl_front.sv
hw/rtl/srl_fifo.sv
hw/rtl/srl_back.sv
hw/rtl/srecord_s1_loader_top.sv
dv/srl_tb_pkg.sv
dv/srecord_s1_loader_top_tb.sv
